>>> rtl/ibbc_pkg.sv
// Shared types, codes and constants of the interrupt batch budget controller.
// No dependencies; used by ibbc_step, ibbc_stats and the top level.
package ibbc_pkg;

	localparam int EVENT_TYPES_DEF = 8;
	localparam int NUM_BATCH_CNT   = 6;
	localparam int CNT_W           = 32;
	localparam int WC_W            = 9;
	localparam int CFG_IDX_W       = 3;

	localparam logic [7:0]      STREAK_YIELD     = 8'd3;
	localparam logic [7:0]      STREAK_EMERGENCY = 8'd5;
	localparam logic [7:0]      STREAK_MAX       = 8'd255;
	localparam logic [WC_W-1:0] COUNT_MAX        = 9'd511;

	// item kinds
	localparam logic [1:0] KIND_STEP  = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// stop reasons
	localparam logic [2:0] RSN_CONTINUE  = 3'd0;
	localparam logic [2:0] RSN_NO_WORK   = 3'd1;
	localparam logic [2:0] RSN_EMERGENCY = 3'd2;
	localparam logic [2:0] RSN_ERROR     = 3'd3;
	localparam logic [2:0] RSN_NO_EVENT  = 3'd4;
	localparam logic [2:0] RSN_YIELD     = 3'd5;
	localparam logic [2:0] RSN_LIMIT     = 3'd6;
	localparam logic [2:0] RSN_DISABLED  = 3'd7;

	// batch counter slots
	localparam int BC_EMERGENCY = 0;
	localparam int BC_ERROR     = 1;
	localparam int BC_YIELD     = 2;
	localparam int BC_LIMIT     = 3;
	localparam int BC_SINGLE    = 4;
	localparam int BC_MULTI     = 5;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WORK_LIM  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_YIELD_THR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TIME  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EMERG_LIM = 3'd4;

	localparam logic [7:0]  RST_WORK_LIM  = 8'd32;
	localparam logic [7:0]  RST_YIELD_THR = 8'd32;
	localparam logic [31:0] RST_MAX_TIME  = 32'd1000;
	localparam logic [7:0]  RST_EMERG_LIM = 8'd64;

	typedef struct packed {
		logic        enabled;
		logic [7:0]  unit_limit;
		logic [7:0]  yield_threshold;
		logic [31:0] time_budget_us;
		logic [7:0]  emergency_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic              more_work;
		logic signed [7:0] work_units;
		logic [3:0]        evt_class;
		logic [31:0]       elapsed_us;
		logic [3:0]        counter_index;
	} item_t;

	typedef struct packed {
		logic [2:0]       stop_reason;
		logic             batch_done;
		logic [WC_W-1:0]  batch_total;
		logic [7:0]       full_streak;
		logic             overload;
		logic             emergency;
		logic [CNT_W-1:0] counter_value;
	} result_t;

	typedef struct packed {
		logic            in_batch;
		logic [WC_W-1:0] work_count;
		logic [WC_W-1:0] batch_sum;
		logic [7:0]      streak;
		logic            overload;
		logic            emergency;
	} state_t;

	// counter update request from the step logic
	typedef struct packed {
		logic                     clear;
		logic [NUM_BATCH_CNT-1:0] bc_bump;
		logic                     type_bump;
		logic [3:0]               type_sel;
	} step_ctl_t;

endpackage

>>> rtl/ibbc_if.sv
// Valid/ready channel interfaces of the batch budget controller: item, result, config.
// Depends on nothing; field widths follow the item and result layouts in ibbc_pkg.
interface ibbc_item_if;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic              more_work;
	logic signed [7:0] work_units;
	logic [3:0]        evt_class;
	logic [31:0]       elapsed_us;
	logic [3:0]        counter_index;

	modport source(output valid, kind, more_work, work_units, evt_class, elapsed_us,
		counter_index, input ready);
	modport sink(input valid, kind, more_work, work_units, evt_class, elapsed_us,
		counter_index, output ready);
endinterface

interface ibbc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  stop_reason;
	logic        batch_done;
	logic [8:0]  batch_total;
	logic [7:0]  full_streak;
	logic        overload;
	logic        emergency;
	logic [31:0] counter_value;

	modport source(output valid, stop_reason, batch_done, batch_total, full_streak, overload,
		emergency, counter_value, input ready);
	modport sink(input valid, stop_reason, batch_done, batch_total, full_streak, overload,
		emergency, counter_value, output ready);
endinterface

interface ibbc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/ibbc_step.sv
// Combinational decision logic for one item: stop reason, next batch state, counter bumps.
// Depends on ibbc_pkg.
module ibbc_step (
	input  ibbc_pkg::item_t     item,
	input  ibbc_pkg::cfg_t      cfg,
	input  ibbc_pkg::state_t    st,
	output ibbc_pkg::state_t    nxt,
	output ibbc_pkg::step_ctl_t ctl,
	output logic [2:0]          reason,
	output logic                done
);

	logic [ibbc_pkg::WC_W-1:0] wc0;
	logic [ibbc_pkg::WC_W-1:0] bs0;
	logic [ibbc_pkg::WC_W:0]   wc_sum;
	logic [ibbc_pkg::WC_W:0]   bs_sum;
	logic [ibbc_pkg::WC_W-1:0] wc_sat;
	logic [ibbc_pkg::WC_W-1:0] bs_sat;
	logic [ibbc_pkg::WC_W-1:0] wlim;
	logic [ibbc_pkg::WC_W-1:0] elim;
	logic [ibbc_pkg::WC_W-1:0] ythr;

	// a new batch starts from zero counts
	assign wc0    = st.in_batch ? st.work_count : '0;
	assign bs0    = st.in_batch ? st.batch_sum : '0;
	assign wc_sum = {1'b0, wc0} + {3'b000, item.work_units[6:0]};
	assign bs_sum = {1'b0, bs0} + {3'b000, item.work_units[6:0]};
	assign wc_sat = wc_sum[ibbc_pkg::WC_W] ? ibbc_pkg::COUNT_MAX : wc_sum[ibbc_pkg::WC_W-1:0];
	assign bs_sat = bs_sum[ibbc_pkg::WC_W] ? ibbc_pkg::COUNT_MAX : bs_sum[ibbc_pkg::WC_W-1:0];
	assign wlim   = {1'b0, cfg.unit_limit};
	assign elim   = {1'b0, cfg.emergency_limit};
	assign ythr   = {1'b0, cfg.yield_threshold};

	always_comb begin
		nxt          = st;
		ctl          = '0;
		ctl.type_sel = item.evt_class;
		reason       = ibbc_pkg::RSN_CONTINUE;
		done         = 1'b0;
		unique case (item.kind)
			ibbc_pkg::KIND_STEP: begin
				if (!cfg.enabled) begin
					reason = ibbc_pkg::RSN_DISABLED;
				end else begin
					nxt.in_batch   = 1'b1;
					nxt.work_count = wc0;
					nxt.batch_sum  = bs0;
					priority if (wc0 >= wlim) begin
						reason = ibbc_pkg::RSN_LIMIT;
					end else if (!item.more_work) begin
						reason = ibbc_pkg::RSN_NO_WORK;
					end else if (wc0 >= elim ||
						(st.overload && st.streak > ibbc_pkg::STREAK_EMERGENCY)) begin
						reason                               = ibbc_pkg::RSN_EMERGENCY;
						nxt.emergency                        = 1'b1;
						ctl.bc_bump[ibbc_pkg::BC_EMERGENCY] = 1'b1;
					end else if (item.work_units[7]) begin
						reason                           = ibbc_pkg::RSN_ERROR;
						ctl.bc_bump[ibbc_pkg::BC_ERROR] = 1'b1;
					end else if (item.work_units == 8'sd0) begin
						reason = ibbc_pkg::RSN_NO_EVENT;
					end else begin
						nxt.work_count = wc_sat;
						nxt.batch_sum  = bs_sat;
						ctl.type_bump  = 1'b1;
						priority if (wc_sat >= ythr || item.elapsed_us > cfg.time_budget_us) begin
							reason                           = ibbc_pkg::RSN_YIELD;
							ctl.bc_bump[ibbc_pkg::BC_YIELD] = 1'b1;
						end else if (st.streak > ibbc_pkg::STREAK_YIELD) begin
							reason                           = ibbc_pkg::RSN_YIELD;
							nxt.overload                     = 1'b1;
							ctl.bc_bump[ibbc_pkg::BC_YIELD] = 1'b1;
						end else if (wc_sat >= wlim) begin
							reason = ibbc_pkg::RSN_LIMIT;
						end else begin
							reason = ibbc_pkg::RSN_CONTINUE;
						end
					end
					// batch end: streak and batch-size statistics
					if (reason != ibbc_pkg::RSN_CONTINUE) begin
						done         = 1'b1;
						nxt.in_batch = 1'b0;
						if (nxt.work_count >= wlim) begin
							ctl.bc_bump[ibbc_pkg::BC_LIMIT] = 1'b1;
							if (st.streak != ibbc_pkg::STREAK_MAX) begin
								nxt.streak = st.streak + 8'd1;
							end
						end else begin
							nxt.streak = '0;
						end
						if (nxt.batch_sum == 9'd1) begin
							ctl.bc_bump[ibbc_pkg::BC_SINGLE] = 1'b1;
						end else if (nxt.batch_sum > 9'd1) begin
							ctl.bc_bump[ibbc_pkg::BC_MULTI] = 1'b1;
						end
					end
				end
			end
			ibbc_pkg::KIND_CLEAR: begin
				ctl.clear     = 1'b1;
				nxt.streak    = '0;
				nxt.overload  = 1'b0;
				nxt.emergency = 1'b0;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/ibbc_stats.sv
// Saturating statistics counters (batch outcomes and per event type) with read mux.
// Depends on ibbc_pkg.
module ibbc_stats #(
	parameter int EVENT_TYPES = ibbc_pkg::EVENT_TYPES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       upd,
	input  ibbc_pkg::step_ctl_t        ctl,
	input  logic [3:0]                 rd_idx,
	output logic [ibbc_pkg::CNT_W-1:0] rd_val
);

	localparam int TW = (EVENT_TYPES > 1) ? $clog2(EVENT_TYPES) : 1;
	localparam logic [4:0] ET = 5'(EVENT_TYPES);
	localparam logic [3:0] TYPE_BASE = 4'(ibbc_pkg::NUM_BATCH_CNT);

	logic [ibbc_pkg::CNT_W-1:0] bcnt_q [ibbc_pkg::NUM_BATCH_CNT];
	logic [ibbc_pkg::CNT_W-1:0] tcnt_q [EVENT_TYPES];
	logic                       ev_ok;
	logic [3:0]                 t_idx;

	assign ev_ok = {1'b0, ctl.type_sel} < ET;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ibbc_pkg::NUM_BATCH_CNT; i++) bcnt_q[i] <= '0;
			for (int i = 0; i < EVENT_TYPES; i++) tcnt_q[i] <= '0;
		end else if (upd) begin
			if (ctl.clear) begin
				for (int i = 0; i < ibbc_pkg::NUM_BATCH_CNT; i++) bcnt_q[i] <= '0;
				for (int i = 0; i < EVENT_TYPES; i++) tcnt_q[i] <= '0;
			end else begin
				for (int i = 0; i < ibbc_pkg::NUM_BATCH_CNT; i++) begin
					if (ctl.bc_bump[i] && bcnt_q[i] != '1) bcnt_q[i] <= bcnt_q[i] + 1'b1;
				end
				for (int i = 0; i < EVENT_TYPES; i++) begin
					if (ctl.type_bump && ev_ok && ctl.type_sel == 4'(i) && tcnt_q[i] != '1) begin
						tcnt_q[i] <= tcnt_q[i] + 1'b1;
					end
				end
			end
		end
	end

	// indexes past the last counter read as zero
	assign t_idx = rd_idx - TYPE_BASE;

	always_comb begin
		rd_val = '0;
		if (rd_idx < TYPE_BASE) begin
			rd_val = bcnt_q[rd_idx[2:0]];
		end else if ({1'b0, t_idx} < ET) begin
			rd_val = tcnt_q[t_idx[TW-1:0]];
		end
	end

endmodule

>>> rtl/interrupt_batch_budget_controller_core.sv
// Interrupt batch budget controller, top level.
// Path: input register, then result register; a result not taken holds the item in stage 1.
// Throughput: one item per cycle unless a result waits; then an empty input register fills.
// Reset (arst_n low): batch state, flags, streak and all counters clear; config returns
// to its defaults (enabled, limits 32/32/64, time 1000 us).
// Depends on ibbc_pkg, ibbc_if, ibbc_step, ibbc_stats.
module interrupt_batch_budget_controller_core #(
	parameter int EVENT_TYPES = ibbc_pkg::EVENT_TYPES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	ibbc_item_if.sink     item,
	ibbc_result_if.source result,
	ibbc_cfg_if.sink      cfg
);

	ibbc_pkg::item_t     item_s1;
	logic                valid_s1;
	ibbc_pkg::result_t   res_s2;
	logic                valid_s2;
	ibbc_pkg::cfg_t      cfg_q;
	ibbc_pkg::state_t    st_q;
	ibbc_pkg::state_t    nxt_st;
	ibbc_pkg::step_ctl_t ctl;
	logic [2:0]          reason;
	logic                done;
	logic [31:0]         rd_val;
	logic                adv;

	// stage 1 moves to the result register when that register is free or being drained
	assign adv        = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || adv;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.kind          <= item.kind;
			item_s1.more_work     <= item.more_work;
			item_s1.work_units    <= item.work_units;
			item_s1.evt_class     <= item.evt_class;
			item_s1.elapsed_us    <= item.elapsed_us;
			item_s1.counter_index <= item.counter_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled         <= 1'b1;
			cfg_q.unit_limit      <= ibbc_pkg::RST_WORK_LIM;
			cfg_q.yield_threshold <= ibbc_pkg::RST_YIELD_THR;
			cfg_q.time_budget_us  <= ibbc_pkg::RST_MAX_TIME;
			cfg_q.emergency_limit <= ibbc_pkg::RST_EMERG_LIM;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				ibbc_pkg::CFG_ENABLED:   cfg_q.enabled         <= cfg.data[0];
				ibbc_pkg::CFG_WORK_LIM:  cfg_q.unit_limit      <= cfg.data[7:0];
				ibbc_pkg::CFG_YIELD_THR: cfg_q.yield_threshold <= cfg.data[7:0];
				ibbc_pkg::CFG_MAX_TIME:  cfg_q.time_budget_us  <= cfg.data;
				ibbc_pkg::CFG_EMERG_LIM: cfg_q.emergency_limit <= cfg.data[7:0];
				default: begin
				end
			endcase
		end
	end

	ibbc_step u_step (
		.item   (item_s1),
		.cfg    (cfg_q),
		.st     (st_q),
		.nxt    (nxt_st),
		.ctl    (ctl),
		.reason (reason),
		.done   (done)
	);

	ibbc_stats #(
		.EVENT_TYPES(EVENT_TYPES)
	) u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv),
		.ctl    (ctl),
		.rd_idx (item_s1.counter_index),
		.rd_val (rd_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= nxt_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2.stop_reason   <= reason;
			res_s2.batch_done    <= done;
			res_s2.batch_total   <= nxt_st.batch_sum;
			res_s2.full_streak   <= nxt_st.streak;
			res_s2.overload      <= nxt_st.overload;
			res_s2.emergency     <= nxt_st.emergency;
			res_s2.counter_value <= (item_s1.kind == ibbc_pkg::KIND_READ) ? rd_val : '0;
		end
	end

	assign result.valid         = valid_s2;
	assign result.stop_reason   = res_s2.stop_reason;
	assign result.batch_done    = res_s2.batch_done;
	assign result.batch_total   = res_s2.batch_total;
	assign result.full_streak   = res_s2.full_streak;
	assign result.overload      = res_s2.overload;
	assign result.emergency     = res_s2.emergency;
	assign result.counter_value = res_s2.counter_value;

`ifndef SYNTH
	// a batch closes only with an item that reports the batch end
	a_batch_close: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(st_q.in_batch) |-> valid_s2 && res_s2.batch_done)
		else $error("batch closed without a batch_done result");

	// batch_done never goes with continue or disabled
	a_done_reason: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.batch_done |->
			res_s2.stop_reason != ibbc_pkg::RSN_CONTINUE &&
			res_s2.stop_reason != ibbc_pkg::RSN_DISABLED)
		else $error("batch_done with a non-ending stop reason");

	// streak only steps up by one or drops to zero
	a_streak_step: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.streak != $past(st_q.streak) |->
			st_q.streak == 8'd0 || st_q.streak == $past(st_q.streak) + 8'd1)
		else $error("streak jumped");

	// emergency flag is raised only by an emergency break
	a_emerg_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st_q.emergency) |-> valid_s2 && res_s2.stop_reason == ibbc_pkg::RSN_EMERGENCY)
		else $error("emergency flag set without an emergency break");
`endif

endmodule
